// File: src/ets_pkg.sv
// Shared types, character codes and token codes for the token splitter.
// No dependencies; imported by every module of the block.
package ets_pkg;

   // Character codes that steer the splitter
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   // Token type codes
   localparam logic [2:0] TT_DEFAULT = 3'd0;
   localparam logic [2:0] TT_STRING  = 3'd1;
   localparam logic [2:0] TT_SPACE   = 3'd2;
   localparam logic [2:0] TT_COMMENT = 3'd3;
   localparam logic [2:0] TT_ARROW   = 3'd4;
   localparam logic [2:0] TT_INST    = 3'd5;

   // Result kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Defaults and sizes
   localparam int SPACE_COUNT_BITS_DEF = 16;
   localparam int MAX_SLOTS            = 5;
   localparam int QUEUE_DEPTH          = 4;
   localparam int QPTR_BITS            = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic [2:0] ttype;
   } slot_type;

   // All results caused by one input item
   typedef struct packed {
      slot_type [MAX_SLOTS-1:0] slots;
      logic [15:0]              run;
      logic [2:0]               count;
   } job_type;

   // Append one result to a job, dropping anything past the last slot
   function automatic job_type job_put(job_type j, logic kind, logic [7:0] ch,
                                       logic [2:0] ttype);
      job_type r;
      r = j;
      if (j.count < 3'(MAX_SLOTS)) begin
         r.slots[j.count].kind  = kind;
         r.slots[j.count].ch    = ch;
         r.slots[j.count].ttype = ttype;
         r.count                = j.count + 3'd1;
      end
      return r;
   endfunction

endpackage

// File: src/ets_front.sv
// Front end: takes characters, tracks the splitter mode and builds the result
// list of each character. Depends on ets_pkg.
module ets_front #(
   parameter int SPACE_COUNT_BITS = ets_pkg::SPACE_COUNT_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [7:0]      in_char,
   input  logic            in_eot,
   input  logic            q_ready,
   output logic            in_ready,
   output logic            q_push,
   output ets_pkg::job_type q_job
);
   import ets_pkg::*;

   localparam int RUN_BITS = (SPACE_COUNT_BITS >= 16) ? 16 : SPACE_COUNT_BITS;
   localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

   typedef enum logic [2:0] {
      M_NORMAL, M_STRING, M_SPACE, M_SLASH, M_DASH
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic                word_ff, word_in;
   logic [RUN_BITS-1:0] run_ff, run_in;
   job_type             job;
   logic                do_norm;
   logic                take;

   assign in_ready = q_ready;
   assign take     = in_valid && q_ready;
   assign q_push   = take && (job.count != 3'd0);
   assign q_job    = job;

   // Classify the character and build its results
   always_comb begin
      job     = '0;
      mode_in = mode_ff;
      word_in = word_ff;
      run_in  = run_ff;
      do_norm = 1'b0;

      case (mode_ff)
         M_STRING: begin
            job = job_put(job, KIND_CHAR, in_char, TT_DEFAULT);
            if (in_char == CH_QUOTE) begin
               job     = job_put(job, KIND_END, 8'd0, TT_STRING);
               mode_in = M_NORMAL;
            end
         end
         M_SPACE: begin
            if (in_char == CH_SPACE) begin
               if (run_ff != RUN_MAX) run_in = run_ff + 1'b1;
            end else begin
               job     = job_put(job, KIND_END, 8'd0, TT_SPACE);
               job.run = 16'(run_ff);
               run_in  = '0;
               mode_in = M_NORMAL;
               do_norm = 1'b1;
            end
         end
         M_SLASH: begin
            mode_in = M_NORMAL;
            if (in_char == CH_SLASH || in_char == CH_STAR) begin
               job = job_put(job, KIND_CHAR, in_char, TT_DEFAULT);
               job = job_put(job, KIND_END, 8'd0, TT_COMMENT);
            end else begin
               job     = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
               do_norm = 1'b1;
            end
         end
         M_DASH: begin
            mode_in = M_NORMAL;
            if (in_char == CH_GT) begin
               if (word_in) job = job_put(job, KIND_END, 8'd0, TT_ARROW);
               word_in = 1'b0;
               job = job_put(job, KIND_CHAR, CH_DASH, TT_DEFAULT);
               job = job_put(job, KIND_CHAR, CH_GT, TT_DEFAULT);
               job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
            end else begin
               job     = job_put(job, KIND_CHAR, CH_DASH, TT_DEFAULT);
               word_in = 1'b1;
               do_norm = 1'b1;
            end
         end
         default: begin
            mode_in = M_NORMAL;
            do_norm = 1'b1;
         end
      endcase

      // Handle the character in normal mode
      if (do_norm) begin
         case (in_char)
            CH_QUOTE: begin
               if (word_in) job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
               word_in = 1'b0;
               job     = job_put(job, KIND_CHAR, in_char, TT_DEFAULT);
               mode_in = M_STRING;
            end
            CH_SPACE: begin
               job     = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
               word_in = 1'b0;
               run_in  = RUN_BITS'(1);
               mode_in = M_SPACE;
            end
            CH_SLASH: begin
               if (word_in) job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
               word_in = 1'b0;
               job     = job_put(job, KIND_CHAR, in_char, TT_DEFAULT);
               mode_in = M_SLASH;
            end
            CH_DASH: begin
               mode_in = M_DASH;
            end
            CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS, CH_COLON, CH_COMMA, CH_SEMI: begin
               if (word_in) job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
               word_in = 1'b0;
               job = job_put(job, KIND_CHAR, in_char, TT_DEFAULT);
               job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
            end
            CH_DOT: begin
               if (word_in) job = job_put(job, KIND_END, 8'd0, TT_INST);
               word_in = 1'b0;
               job = job_put(job, KIND_CHAR, in_char, TT_DEFAULT);
               job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
            end
            default: begin
               job     = job_put(job, KIND_CHAR, in_char, TT_DEFAULT);
               word_in = 1'b1;
            end
         endcase
      end

      // Flush pending state on the final character
      if (in_eot) begin
         case (mode_in)
            M_STRING: begin
               job = job_put(job, KIND_END, 8'd0, TT_STRING);
            end
            M_SPACE: begin
               job     = job_put(job, KIND_END, 8'd0, TT_SPACE);
               job.run = 16'(run_in);
               job     = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
            end
            M_SLASH: begin
               job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
               job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
            end
            M_DASH: begin
               job = job_put(job, KIND_CHAR, CH_DASH, TT_DEFAULT);
               job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
            end
            default: begin
               job = job_put(job, KIND_END, 8'd0, TT_DEFAULT);
            end
         endcase
         mode_in = M_NORMAL;
         word_in = 1'b0;
         run_in  = '0;
      end
   end

   // Hold mode state, advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_NORMAL;
         word_ff <= 1'b0;
         run_ff  <= '0;
      end else if (take) begin
         mode_ff <= mode_in;
         word_ff <= word_in;
         run_ff  <= run_in;
      end
   end

endmodule

// File: src/ets_queue.sv
// Short job queue between the front end and the result sequencer.
// Depends on ets_pkg.
module ets_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ets_pkg::job_type push_job,
   output logic             push_ready,
   input  logic             pop,
   output logic             head_valid,
   output ets_pkg::job_type head_job
);
   import ets_pkg::*;

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in;
   logic [QPTR_BITS-1:0] rd_ff, rd_in;
   logic [QPTR_BITS:0]   cnt_ff, cnt_in;

   assign push_ready = (cnt_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem_ff[rd_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

endmodule

// File: src/ets_back.sv
// Result sequencer: walks the slots of the head job and drives the output
// register, one result per beat. Depends on ets_pkg.
module ets_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ets_pkg::job_type head_job,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_kind,
   output logic [7:0]       out_char,
   output logic [2:0]       out_type,
   output logic [15:0]      out_run,
   output logic             out_last
);
   import ets_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic        kind_ff;
   logic [7:0]  char_ff;
   logic [2:0]  type_ff;
   logic [15:0] run_ff;
   logic        last_ff;
   logic        load;
   logic        is_last;
   slot_type    slot;

   assign slot    = head_job.slots[idx_ff];
   assign is_last = (idx_ff == head_job.count - 3'd1);
   assign load    = head_valid && (!valid_ff || out_ready);
   assign pop     = load && is_last;

   // Step through the slots; drop the job after its last one
   always_comb begin
      if (pop) idx_in = '0;
      else if (load) idx_in = idx_ff + 3'd1;
      else idx_in = idx_ff;
      if (load) valid_in = 1'b1;
      else if (out_ready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= slot.kind;
         char_ff <= slot.ch;
         type_ff <= slot.ttype;
         run_ff  <= (slot.kind == KIND_END && slot.ttype == TT_SPACE) ? head_job.run : 16'd0;
         last_ff <= is_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_char  = char_ff;
   assign out_type  = type_ff;
   assign out_run   = run_ff;
   assign out_last  = last_ff;

endmodule

// File: src/editor_token_splitter_unit.sv
// Token splitter for editor text: one character per beat in, token characters
// and token-end markers out; results pass through the job queue and the output register.
// Throughput: one character per cycle when each causes one result and rsp_tready is high;
// the output sequencer sends one result per cycle, so characters with more back up the queue.
// Synchronous active-high reset returns the splitter to normal mode with no open word.
module editor_token_splitter_unit #(
   parameter int SPACE_COUNT_BITS = ets_pkg::SPACE_COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] token_char, [10:8] token_type, [26:11] run_length
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last_in_run
);
   import ets_pkg::*;

   logic        q_ready;
   logic        q_push;
   job_type     q_job;
   logic        pop;
   logic        head_valid;
   job_type     head_job;
   logic [7:0]  out_char;
   logic [2:0]  out_type;
   logic [15:0] out_run;

   ets_front #(
      .SPACE_COUNT_BITS(SPACE_COUNT_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_char  (req_tdata),
      .in_eot   (req_tlast),
      .q_ready  (q_ready),
      .in_ready (req_tready),
      .q_push   (q_push),
      .q_job    (q_job)
   );

   ets_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .push_ready (q_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   ets_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (rsp_tuser),
      .out_char   (out_char),
      .out_type   (out_type),
      .out_run    (out_run),
      .out_last   (rsp_tlast)
   );

   // Pack result fields, low bits first
   assign rsp_tdata = {5'd0, out_run, out_type, out_char};

endmodule
